[sv/tmh_pkg.sv]
`default_nettype none
package tmh_pkg;

  localparam int unsigned Capacity = 64;
  localparam int unsigned IdW      = 6;
  localparam int unsigned IdxW     = $clog2(Capacity);
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned TimeW    = 64;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_ABSENT  = 2'd2;
  localparam logic [1:0] ST_PRESENT = 2'd3;

  typedef enum logic [2:0] {
    RS_ROOT, RS_PARENT, RS_LEFT, RS_RIGHT, RS_LAST
  } rd_sel_e;

  typedef enum logic [1:0] {
    WS_CUR, WS_RD, WS_CH
  } wr_sel_e;

  typedef enum logic [2:0] {
    IS_HOLD, IS_PARENT, IS_POS, IS_ZERO, IS_CHILD, IS_COUNT
  } idx_sel_e;

  typedef enum logic [1:0] {
    CN_HOLD, CN_INC, CN_DEC
  } cnt_op_e;

  typedef struct packed {
    logic       latch;
    logic       rd_en;
    rd_sel_e    rd_sel;
    logic       wr_en;
    wr_sel_e    wr_sel;
    idx_sel_e   idx_sel;
    cnt_op_e    cnt_op;
    logic       cur_rd;
    logic       ch_rd;
    logic       ch_right;
    logic       pres_set;
    logic       pres_clr_id;
    logic       pres_clr_rd;
    logic       pend_set;
    logic       pend_clr;
    logic       emit;
    logic [1:0] emit_status;
    logic       emit_fired;
    logic       emit_last;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       present;
    logic       full;
    logic       cnt_zero;
    logic       cnt_one;
    logic       idx_zero;
    logic       pos_is_last;
    logic       cur_lt_rd;
    logic       cur_lt_ch;
    logic       ch_lt_rd;
    logic       rd_le_now;
    logic       left_out;
    logic       right_in;
    logic       pend;
  } sts_t;

endpackage
`default_nettype wire

[sv/tmh_datapath.sv]
`default_nettype none
module tmh_datapath import tmh_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cmd_t             cmd_i,
  input  wire logic [1:0]       operation_i,
  input  wire logic [IdW-1:0]   timer_id_i,
  input  wire logic [TimeW-1:0] expires_i,
  input  wire logic [TimeW-1:0] now_i,
  output sts_t                  sts_o,
  output logic                  valid_o,
  output logic [1:0]            status_o,
  output logic                  fired_o,
  output logic [IdW-1:0]        fired_id_o,
  output logic                  last_o,
  output logic [CntW-1:0]       pending_o
);

  logic [TimeW-1:0] time_mem [Capacity];
  logic [IdW-1:0]   own_mem  [Capacity];
  logic [IdxW-1:0]  pos_mem  [2**IdW];

  logic [1:0]       op_q;
  logic [IdW-1:0]   id_q;
  logic [TimeW-1:0] now_q;
  logic [TimeW-1:0] cur_time_q;
  logic [IdW-1:0]   cur_own_q;
  logic [TimeW-1:0] rd_time_q;
  logic [IdW-1:0]   rd_own_q;
  logic [TimeW-1:0] ch_time_q;
  logic [IdW-1:0]   ch_own_q;
  logic             ch_right_q;
  logic [IdxW-1:0]  pos_q;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [2**IdW-1:0] present_q;
  logic             pend_q;
  logic [IdW-1:0]   pend_id_q;
  logic             valid_q;

  logic [CntW:0]    left_c;
  logic [CntW:0]    right_c;
  logic [IdxW-1:0]  parent;
  logic [CntW-1:0]  last_slot;
  logic [IdxW-1:0]  raddr;
  logic [TimeW-1:0] wtime;
  logic [IdW-1:0]   wown;

  assign left_c    = {1'b0, idx_q, 1'b1};
  assign right_c   = left_c + 1'b1;
  assign parent    = (idx_q - 1'b1) >> 1;
  assign last_slot = cnt_q - 1'b1;

  always_comb begin
    unique case (cmd_i.rd_sel)
      RS_ROOT:   raddr = '0;
      RS_PARENT: raddr = parent;
      RS_LEFT:   raddr = left_c[IdxW-1:0];
      RS_RIGHT:  raddr = right_c[IdxW-1:0];
      RS_LAST:   raddr = last_slot[IdxW-1:0];
      default:   raddr = '0;
    endcase
  end

  always_comb begin
    unique case (cmd_i.wr_sel)
      WS_CUR:  begin wtime = cur_time_q; wown = cur_own_q; end
      WS_RD:   begin wtime = rd_time_q;  wown = rd_own_q;  end
      WS_CH:   begin wtime = ch_time_q;  wown = ch_own_q;  end
      default: begin wtime = cur_time_q; wown = cur_own_q; end
    endcase
  end

  always_comb begin
    unique case (cmd_i.idx_sel)
      IS_HOLD:   idx_d = idx_q;
      IS_PARENT: idx_d = parent;
      IS_POS:    idx_d = pos_q;
      IS_ZERO:   idx_d = '0;
      IS_CHILD:  idx_d = ch_right_q ? right_c[IdxW-1:0] : left_c[IdxW-1:0];
      IS_COUNT:  idx_d = cnt_q[IdxW-1:0];
      default:   idx_d = idx_q;
    endcase
    unique case (cmd_i.cnt_op)
      CN_HOLD: cnt_d = cnt_q;
      CN_INC:  cnt_d = cnt_q + 1'b1;
      CN_DEC:  cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  // Heap storage and the id-to-slot table move together on every write.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      time_mem[idx_q] <= wtime;
      own_mem[idx_q]  <= wown;
      pos_mem[wown]   <= idx_q;
    end
    if (cmd_i.rd_en) begin
      rd_time_q <= time_mem[raddr];
      rd_own_q  <= own_mem[raddr];
    end
    if (cmd_i.latch) begin
      pos_q <= pos_mem[timer_id_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q       <= operation_i;
      id_q       <= timer_id_i;
      now_q      <= now_i;
      cur_time_q <= expires_i;
      cur_own_q  <= timer_id_i;
    end else if (cmd_i.cur_rd) begin
      cur_time_q <= rd_time_q;
      cur_own_q  <= rd_own_q;
    end
    if (cmd_i.ch_rd) begin
      ch_time_q  <= rd_time_q;
      ch_own_q   <= rd_own_q;
      ch_right_q <= cmd_i.ch_right;
    end
    idx_q <= idx_d;
    if (cmd_i.pend_set) begin
      pend_id_q <= rd_own_q;
    end
    if (cmd_i.emit) begin
      status_o   <= cmd_i.emit_status;
      fired_o    <= cmd_i.emit_fired;
      fired_id_o <= cmd_i.emit_fired ? pend_id_q : '0;
      last_o     <= cmd_i.emit_last;
      pending_o  <= cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      present_q <= '0;
      pend_q    <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      valid_q <= cmd_i.emit;
      if (cmd_i.pres_set)    present_q[id_q]     <= 1'b1;
      if (cmd_i.pres_clr_id) present_q[id_q]     <= 1'b0;
      if (cmd_i.pres_clr_rd) present_q[rd_own_q] <= 1'b0;
      if (cmd_i.pend_set)      pend_q <= 1'b1;
      else if (cmd_i.pend_clr) pend_q <= 1'b0;
    end
  end

  assign valid_o = valid_q;

  always_comb begin
    sts_o.op          = op_q;
    sts_o.present     = present_q[id_q];
    sts_o.full        = (cnt_q == CntW'(Capacity));
    sts_o.cnt_zero    = (cnt_q == '0);
    sts_o.cnt_one     = (cnt_q == CntW'(1));
    sts_o.idx_zero    = (idx_q == '0);
    sts_o.pos_is_last = ({1'b0, pos_q} == last_slot);
    sts_o.cur_lt_rd   = (cur_time_q < rd_time_q);
    sts_o.cur_lt_ch   = (cur_time_q < ch_time_q);
    sts_o.ch_lt_rd    = (ch_time_q < rd_time_q);
    sts_o.rd_le_now   = (rd_time_q <= now_q);
    sts_o.left_out    = (left_c >= {1'b0, cnt_q});
    sts_o.right_in    = (right_c < {1'b0, cnt_q});
    sts_o.pend        = pend_q;
  end

endmodule
`default_nettype wire

[sv/tmh_ctrl.sv]
`default_nettype none
module tmh_ctrl import tmh_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o,
  output logic      busy_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_RMLAST = 4'd2;
  localparam logic [3:0] S_RMPAR  = 4'd3;
  localparam logic [3:0] S_UPRD   = 4'd4;
  localparam logic [3:0] S_UPCMP  = 4'd5;
  localparam logic [3:0] S_DNRD   = 4'd6;
  localparam logic [3:0] S_DNL    = 4'd7;
  localparam logic [3:0] S_DNR    = 4'd8;
  localparam logic [3:0] S_DNCMP  = 4'd9;
  localparam logic [3:0] S_FINISH = 4'd10;
  localparam logic [3:0] S_TKCHK  = 4'd11;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts_i.op)
          OP_ADD: begin
            if (sts_i.present || sts_i.full) begin
              cmd_o.emit        = 1'b1;
              cmd_o.emit_status = sts_i.present ? ST_PRESENT : ST_FULL;
              cmd_o.emit_last   = 1'b1;
              state_d           = S_IDLE;
            end else begin
              cmd_o.pres_set = 1'b1;
              cmd_o.cnt_op   = CN_INC;
              cmd_o.idx_sel  = IS_COUNT;
              state_d        = S_UPRD;
            end
          end
          OP_REMOVE: begin
            if (!sts_i.present) begin
              cmd_o.emit        = 1'b1;
              cmd_o.emit_status = ST_ABSENT;
              cmd_o.emit_last   = 1'b1;
              state_d           = S_IDLE;
            end else begin
              cmd_o.pres_clr_id = 1'b1;
              cmd_o.cnt_op      = CN_DEC;
              if (sts_i.pos_is_last) begin
                state_d = S_FINISH;
              end else begin
                cmd_o.idx_sel = IS_POS;
                cmd_o.rd_en   = 1'b1;
                cmd_o.rd_sel  = RS_LAST;
                state_d       = S_RMLAST;
              end
            end
          end
          OP_TICK: begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = RS_ROOT;
            state_d      = S_TKCHK;
          end
          default: begin
            cmd_o.emit      = 1'b1;
            cmd_o.emit_last = 1'b1;
            state_d         = S_IDLE;
          end
        endcase
      end
      S_RMLAST: begin
        cmd_o.cur_rd = 1'b1;
        if (sts_i.idx_zero) begin
          state_d = S_DNRD;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RS_PARENT;
          state_d      = S_RMPAR;
        end
      end
      S_RMPAR: begin
        if (sts_i.cur_lt_rd) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_sel  = WS_RD;
          cmd_o.idx_sel = IS_PARENT;
          state_d       = S_UPRD;
        end else begin
          state_d = S_DNRD;
        end
      end
      S_UPRD: begin
        if (sts_i.idx_zero) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = WS_CUR;
          state_d      = S_FINISH;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RS_PARENT;
          state_d      = S_UPCMP;
        end
      end
      S_UPCMP: begin
        cmd_o.wr_en = 1'b1;
        if (sts_i.cur_lt_rd) begin
          cmd_o.wr_sel  = WS_RD;
          cmd_o.idx_sel = IS_PARENT;
          state_d       = S_UPRD;
        end else begin
          cmd_o.wr_sel = WS_CUR;
          state_d      = S_FINISH;
        end
      end
      S_DNRD: begin
        if (sts_i.left_out) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = WS_CUR;
          state_d      = S_FINISH;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RS_LEFT;
          state_d      = S_DNL;
        end
      end
      S_DNL: begin
        cmd_o.ch_rd = 1'b1;
        if (sts_i.right_in) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RS_RIGHT;
          state_d      = S_DNR;
        end else begin
          state_d = S_DNCMP;
        end
      end
      S_DNR: begin
        // The right child wins unless the left one is strictly earlier.
        if (!sts_i.ch_lt_rd) begin
          cmd_o.ch_rd    = 1'b1;
          cmd_o.ch_right = 1'b1;
        end
        state_d = S_DNCMP;
      end
      S_DNCMP: begin
        cmd_o.wr_en = 1'b1;
        if (sts_i.cur_lt_ch) begin
          cmd_o.wr_sel = WS_CUR;
          state_d      = S_FINISH;
        end else begin
          cmd_o.wr_sel  = WS_CH;
          cmd_o.idx_sel = IS_CHILD;
          state_d       = S_DNRD;
        end
      end
      S_FINISH: begin
        if (sts_i.op == OP_TICK) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RS_ROOT;
          state_d      = S_TKCHK;
        end else begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_last = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_TKCHK: begin
        // A fired id is held back until the next root check shows whether it is last.
        if (!sts_i.cnt_zero && sts_i.rd_le_now) begin
          cmd_o.emit        = sts_i.pend;
          cmd_o.emit_fired  = 1'b1;
          cmd_o.pend_set    = 1'b1;
          cmd_o.pres_clr_rd = 1'b1;
          cmd_o.cnt_op      = CN_DEC;
          if (sts_i.cnt_one) begin
            state_d = S_FINISH;
          end else begin
            cmd_o.idx_sel = IS_ZERO;
            cmd_o.rd_en   = 1'b1;
            cmd_o.rd_sel  = RS_LAST;
            state_d       = S_RMLAST;
          end
        end else begin
          cmd_o.emit       = 1'b1;
          cmd_o.emit_fired = sts_i.pend;
          cmd_o.emit_last  = 1'b1;
          cmd_o.pend_clr   = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule
`default_nettype wire

[sv/timer_min_heap_unit.sv]
// Channel | Ports                                         | Transaction
// --------+-----------------------------------------------+---------------------------
// command | start_i, busy_o, operation_i, timer_id_i,      | start_i high, busy_o low
//         | expires_i, now_i                              |
// result  | valid_o, status_o, fired_o, fired_id_o,        | valid_o high, one cycle
//         | last_o, pending_o                             |
//
// An add sifts the new entry up from the last slot; each sift-up level reads the
// parent, then compares and writes. A remove of the last slot skips sifting; each
// sift-down level reads the children through the single heap read port.
// A tick checks the root before each removal of a fired timer and once at the end.
// The final result strobe comes in the first cycle with busy_o low again.
// Reset clears the count, the presence bits and the controller; no clearing pass.
// The receiver cannot stall; results appear once and are not held.
`default_nettype none
module timer_min_heap_unit import tmh_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  output logic                  busy_o,
  input  wire logic [1:0]       operation_i,
  input  wire logic [IdW-1:0]   timer_id_i,
  input  wire logic [TimeW-1:0] expires_i,
  input  wire logic [TimeW-1:0] now_i,
  output logic                  valid_o,
  output logic [1:0]            status_o,
  output logic                  fired_o,
  output logic [IdW-1:0]        fired_id_o,
  output logic                  last_o,
  output logic [CntW-1:0]       pending_o
);

  cmd_t cmd;
  sts_t sts;

  tmh_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy_o)
  );

  tmh_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .operation_i(operation_i),
    .timer_id_i (timer_id_i),
    .expires_i  (expires_i),
    .now_i      (now_i),
    .sts_o      (sts),
    .valid_o    (valid_o),
    .status_o   (status_o),
    .fired_o    (fired_o),
    .fired_id_o (fired_id_o),
    .last_o     (last_o),
    .pending_o  (pending_o)
  );

endmodule
`default_nettype wire
